[rtl/fft_256_int16_block_scaled_defines.svh]
// Assertion macros used by the top-level FFT module.
`ifndef FFT_256_INT16_BLOCK_SCALED_DEFINES_SVH
`define FFT_256_INT16_BLOCK_SCALED_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFT_ASSERT_HOLDS(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("fft assertion failed");
`define FFT_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("fft assertion failed");
`else
`define FFT_ASSERT_HOLDS(lbl, prop)
`define FFT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

[rtl/fft256_pkg.sv]
`timescale 1ns / 1ps
package fft256_pkg;

	typedef struct packed {
		logic               opcode;
		logic signed [15:0] sample_re;
		logic signed [15:0] sample_im;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] result_re;
		logic signed [15:0] result_im;
		logic        [7:0]  bin_index;
		logic               last_bin;
		logic               status;
	} out_item_t;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_UNLOAD = 1'b1;

	localparam int LATE_STAGE = 5;
	localparam int ROUND_BIAS = 16384;
	localparam int PROD_SHIFT = 15;
	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
	localparam logic [63:0] TAYLOR_DIV [12] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
		64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UNLD,
		ST_RA,
		ST_RB,
		ST_MUL,
		ST_ADD,
		ST_WA,
		ST_WB
	} state_t;

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ah, al, bh, bl;
		ah = a >> 32;
		al = a & 64'hFFFF_FFFF;
		bh = b >> 32;
		bl = b & 64'hFFFF_FFFF;
		return ah * bh * 64'd16 + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
	endfunction

	function automatic logic [63:0] sine_q60(input logic [63:0] x);
		logic [63:0] x2, term, sum;
		x2 = mul_q60(x, x);
		term = x;
		sum = x;
		for (int n = 1; n <= 12; n++) begin
			term = mul_q60(term, x2) / TAYLOR_DIV[n - 1];
			if ((n & 1) == 1) sum = sum - term;
			else sum = sum + term;
		end
		return sum;
	endfunction

	function automatic logic [15:0] quarter_q15(input int m, input logic [63:0] step);
		logic [63:0] v;
		v = (((sine_q60(step * 64'(m)) >> 20) * 64'd32767) + (64'd1 << 39)) >> 40;
		return (v > 64'd32767) ? 16'd32767 : v[15:0];
	endfunction

	// cos in the upper half, negative sine in the lower half
	function automatic logic [31:0] twiddle_entry(input int j, input int points,
			input logic [63:0] step);
		int q;
		logic [15:0] c, s;
		q = points / 4;
		if (j <= q) begin
			c = quarter_q15(q - j, step);
			s = quarter_q15(j, step);
		end else begin
			c = 16'(-quarter_q15(j - q, step));
			s = quarter_q15(2 * q - j, step);
		end
		return {c, 16'(-s)};
	endfunction

endpackage

[rtl/fft_256_int16_block_scaled.sv]
`timescale 1ns / 1ps
// Block FFT, radix-2 decimation in time, 16-bit complex samples, Q15 twiddles.
// Input channel (in_valid/in_ready/in_data) carries load and unload requests.
// A load request stores one sample (natural order, placed bit-reversed). The
// POINTS-th load starts the transform: log2(POINTS) stages of POINTS/2
// butterflies, each through the states RA, RB, MUL, ADD, WA and WB, all
// through the one read port and one write port of the sample memory. No
// request is taken while it runs.
// An unload request returns the next bin on the output channel via state
// UNLD and the output register (out_valid/out_ready/out_data); no request
// is taken in UNLD. With no frame ready it returns status 1 in the next cycle.
// Unloads are taken when the output register is free or being emptied; loads
// are taken while a result waits.
// A stalled receiver holds the output register and so holds further unloads.
// cfg_valid/cfg_data writes skip_late_scaling; cfg_ready is always high.
// Reset clears counters, the frame and skip flags and out_valid, not the output
// data; the sample memory is not cleared and needs no clearing pass.
`include "fft_256_int16_block_scaled_defines.svh"
module fft_256_int16_block_scaled #(
	parameter int POINTS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  fft256_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output fft256_pkg::out_item_t out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data
);

	localparam int LG = $clog2(POINTS);
	localparam int STW = $clog2(LG);
	localparam logic [63:0] STEP_Q60 = fft256_pkg::HALF_PI_Q60 / 64'(POINTS / 4);

	logic [31:0] tw_rom [POINTS / 2];

	for (genvar j = 0; j < POINTS / 2; j++) begin : g_tw
		localparam logic [31:0] TWJ = fft256_pkg::twiddle_entry(j, POINTS, STEP_Q60);
		assign tw_rom[j] = TWJ;
	end

	fft256_pkg::state_t state_q, state_d;
	logic [LG-1:0]  load_cnt_q, unload_cnt_q;
	logic           frame_q, skip_q, out_valid_q;
	logic [LG-2:0]  k_q;
	logic [STW-1:0] st_q;
	logic [31:0]    a_q, tw_q, rdata_q;
	fft256_pkg::out_item_t out_data_q;

	logic [31:0] mem [POINTS];
	logic          mem_we;
	logic [LG-1:0] mem_wa, mem_ra;
	logic [31:0]   mem_wd;

	logic          accept, is_load, slot_free, last_bfly, sh;
	logic [LG-1:0] kk, lowmask, span_bit, addr_a, addr_b, rev;
	logic [LG-2:0] tw_idx;
	logic [LG+7:0] bin_ext;
	logic [31:0]   ya, yb;

	assign cfg_ready = 1'b1;
	assign is_load = (in_data.opcode == fft256_pkg::OP_LOAD);
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == fft256_pkg::ST_IDLE) && (is_load || slot_free);
	assign accept = in_valid && in_ready;

	always_comb begin
		for (int i = 0; i < LG; i++) rev[i] = load_cnt_q[LG-1-i];
		kk = {1'b0, k_q};
		lowmask = ~({LG{1'b1}} << st_q);
		span_bit = {{(LG-1){1'b0}}, 1'b1} << st_q;
		addr_a = (kk & lowmask) | ((kk & ~lowmask) << 1);
		addr_b = addr_a | span_bit;
		tw_idx = (LG-1)'((kk & lowmask) << (LG - 1 - int'(st_q)));
		last_bfly = (&k_q) && (st_q == STW'(LG - 1));
		sh = !(skip_q && (st_q >= STW'(fft256_pkg::LATE_STAGE)));
		bin_ext = (LG+8)'(unload_cnt_q);
	end

	fft256_bfly u_bfly (
		.clk (clk),
		.a   (a_q),
		.b   (rdata_q),
		.tw  (tw_q),
		.sh  (sh),
		.ya  (ya),
		.yb  (yb)
	);

	always_comb begin
		state_d = state_q;
		mem_we = 1'b0;
		mem_wa = addr_a;
		mem_wd = ya;
		mem_ra = addr_a;
		unique case (state_q)
			fft256_pkg::ST_IDLE: begin
				mem_ra = unload_cnt_q;
				if (accept && is_load) begin
					mem_we = 1'b1;
					mem_wa = rev;
					mem_wd = {in_data.sample_re, in_data.sample_im};
					if (&load_cnt_q) state_d = fft256_pkg::ST_RA;
				end else if (accept && frame_q) begin
					state_d = fft256_pkg::ST_UNLD;
				end
			end
			fft256_pkg::ST_UNLD: state_d = fft256_pkg::ST_IDLE;
			fft256_pkg::ST_RA:   state_d = fft256_pkg::ST_RB;
			fft256_pkg::ST_RB: begin
				mem_ra = addr_b;
				state_d = fft256_pkg::ST_MUL;
			end
			// hold the lower operand on the read port through ST_ADD so both outputs stay valid for the writes
			fft256_pkg::ST_MUL: begin
				mem_ra = addr_b;
				state_d = fft256_pkg::ST_ADD;
			end
			fft256_pkg::ST_ADD: begin
				mem_ra = addr_b;
				state_d = fft256_pkg::ST_WA;
			end
			fft256_pkg::ST_WA: begin
				mem_we = 1'b1;
				state_d = fft256_pkg::ST_WB;
			end
			fft256_pkg::ST_WB: begin
				mem_we = 1'b1;
				mem_wa = addr_b;
				mem_wd = yb;
				state_d = last_bfly ? fft256_pkg::ST_IDLE : fft256_pkg::ST_RA;
			end
			default: state_d = fft256_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fft256_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			unload_cnt_q <= '0;
			frame_q <= 1'b0;
			skip_q <= 1'b0;
			out_valid_q <= 1'b0;
			k_q <= '0;
			st_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) skip_q <= cfg_data;
			if ((state_q == fft256_pkg::ST_IDLE && accept && !is_load && !frame_q)
					|| state_q == fft256_pkg::ST_UNLD) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == fft256_pkg::ST_IDLE && accept && is_load) begin
				// abandon any pending frame
				frame_q <= 1'b0;
				unload_cnt_q <= '0;
				load_cnt_q <= load_cnt_q + 1'b1;
				k_q <= '0;
				st_q <= '0;
			end
			if (state_q == fft256_pkg::ST_UNLD) begin
				unload_cnt_q <= unload_cnt_q + 1'b1;
				if (&unload_cnt_q) frame_q <= 1'b0;
			end
			if (state_q == fft256_pkg::ST_WB) begin
				k_q <= k_q + 1'b1;
				if (&k_q) st_q <= st_q + 1'b1;
				if (last_bfly) begin
					frame_q <= 1'b1;
					unload_cnt_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fft256_pkg::ST_RB) tw_q <= tw_rom[tw_idx];
		if (state_q == fft256_pkg::ST_RB) a_q <= rdata_q;
		if (state_q == fft256_pkg::ST_IDLE && accept && !is_load && !frame_q) begin
			out_data_q.result_re <= '0;
			out_data_q.result_im <= '0;
			out_data_q.bin_index <= '0;
			out_data_q.last_bin <= 1'b0;
			out_data_q.status <= 1'b1;
		end
		if (state_q == fft256_pkg::ST_UNLD) begin
			out_data_q.result_re <= $signed(rdata_q[31:16]);
			out_data_q.result_im <= $signed(rdata_q[15:0]);
			out_data_q.bin_index <= bin_ext[7:0];
			out_data_q.last_bin <= &unload_cnt_q;
			out_data_q.status <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	`FFT_ASSERT_HOLDS(a_frame_no_partial_load, !frame_q || (load_cnt_q == '0))
	`FFT_ASSERT_NEXT(a_load_drops_frame, accept && is_load, !frame_q)
	`FFT_ASSERT_NEXT(a_transform_ends_ready, state_q == fft256_pkg::ST_WB && last_bfly, frame_q)
	`FFT_ASSERT_NEXT(a_unload_has_slot, state_q == fft256_pkg::ST_UNLD, out_valid_q)

endmodule

[rtl/fft256_bfly.sv]
`timescale 1ns / 1ps
module fft256_bfly (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] tw,
	input  logic        sh,
	output logic [31:0] ya,
	output logic [31:0] yb
);

	logic signed [31:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [15:0] ar_s1, ai_s1;
	logic               sh_s1;
	logic signed [33:0] sum_re, sum_im;
	logic signed [19:0] t_re, t_im, ar_x, ai_x;
	logic signed [19:0] dr, di, ur, ui;
	logic        [31:0] ya_s2, yb_s2;

	always_ff @(posedge clk) begin
		p_rr_s1 <= $signed(b[31:16]) * $signed(tw[31:16]);
		p_ii_s1 <= $signed(b[15:0]) * $signed(tw[15:0]);
		p_ri_s1 <= $signed(b[31:16]) * $signed(tw[15:0]);
		p_ir_s1 <= $signed(b[15:0]) * $signed(tw[31:16]);
		ar_s1 <= $signed(a[31:16]);
		ai_s1 <= $signed(a[15:0]);
		sh_s1 <= sh;
	end

	always_comb begin
		sum_re = 34'(p_rr_s1) - 34'(p_ii_s1) + 34'(fft256_pkg::ROUND_BIAS);
		sum_im = 34'(p_ri_s1) + 34'(p_ir_s1) + 34'(fft256_pkg::ROUND_BIAS);
		t_re = 20'(sum_re >>> fft256_pkg::PROD_SHIFT);
		t_im = 20'(sum_im >>> fft256_pkg::PROD_SHIFT);
		ar_x = 20'(ar_s1);
		ai_x = 20'(ai_s1);
		dr = ar_x - t_re;
		di = ai_x - t_im;
		ur = ar_x + t_re;
		ui = ai_x + t_im;
		if (sh_s1) begin
			dr = dr >>> 1;
			di = di >>> 1;
			ur = ur >>> 1;
			ui = ui >>> 1;
		end
	end

	// wrap to 16 bits
	always_ff @(posedge clk) begin
		ya_s2 <= {ur[15:0], ui[15:0]};
		yb_s2 <= {dr[15:0], di[15:0]};
	end

	assign ya = ya_s2;
	assign yb = yb_s2;

endmodule
